// ----- design/svg_pkg.sv -----
// Shared types and constants for the sphere vertex generator.
// Used by the CORDIC cells, the post-processing pipeline and the top level.
// No dependencies.
`timescale 1ns / 1ps

package svg_pkg;

  // Register indexes of the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_RADIUS        = 3'd0;
  localparam logic [2:0] REG_RING_COUNT    = 3'd1;
  localparam logic [2:0] REG_SEGMENT_COUNT = 3'd2;
  localparam logic [2:0] REG_RING_STEP     = 3'd3;
  localparam logic [2:0] REG_SEGMENT_STEP  = 3'd4;

  localparam logic [15:0] RADIUS_RESET        = 16'd256;
  localparam logic [8:0]  RING_COUNT_RESET    = 9'd8;
  localparam logic [8:0]  SEGMENT_COUNT_RESET = 9'd8;
  localparam logic [15:0] RING_STEP_RESET     = 16'd4096;
  localparam logic [15:0] SEGMENT_STEP_RESET  = 16'd8192;

  // CORDIC runs on a 32-bit turn angle and Q2.30 data.
  localparam int ATAN_ENTRIES = 24;
  localparam int INT_FRAC     = 30;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD_3B6A;
  localparam logic signed [31:0] EIGHTH_TURN = 32'sh2000_0000;

  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int POS_LIMIT = 65535;

  // Rotation state of the polar (b) and azimuth (t) CORDIC channels.
  typedef struct packed {
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic signed [31:0] zb;
    logic signed [31:0] xt;
    logic signed [31:0] yt;
    logic signed [31:0] zt;
  } cordic_t;

  // Per-vertex control that rides along with the rotation state.
  typedef struct packed {
    logic       pole;
    logic       err;
    logic       south;
    logic [1:0] qb;
    logic [1:0] qt;
  } ctrl_t;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic               is_pole;
    logic               index_error;
  } vertex_t;

endpackage

// ----- design/svg_cordic_cell.sv -----
// One CORDIC micro-rotation for both angle channels, with its pipeline register.
// Depends on svg_pkg for the rotation state, control struct and arctangent table.
`timescale 1ns / 1ps

module svg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  svg_pkg::cordic_t in_dat,
  input  svg_pkg::ctrl_t   in_ctl,
  output logic            out_valid,
  input  logic            out_ready,
  output svg_pkg::cordic_t out_dat,
  output svg_pkg::ctrl_t   out_ctl
);

  localparam logic signed [31:0] ANGLE = signed'(svg_pkg::ATAN_TURN32[STAGE]);

  logic             vld;
  svg_pkg::cordic_t dat;
  svg_pkg::ctrl_t   ctl;
  svg_pkg::cordic_t dat_next;

  always_comb begin
    dat_next = in_dat;
    if (!in_dat.zb[31]) begin
      dat_next.xb = in_dat.xb - (in_dat.yb >>> STAGE);
      dat_next.yb = in_dat.yb + (in_dat.xb >>> STAGE);
      dat_next.zb = in_dat.zb - ANGLE;
    end else begin
      dat_next.xb = in_dat.xb + (in_dat.yb >>> STAGE);
      dat_next.yb = in_dat.yb - (in_dat.xb >>> STAGE);
      dat_next.zb = in_dat.zb + ANGLE;
    end
    if (!in_dat.zt[31]) begin
      dat_next.xt = in_dat.xt - (in_dat.yt >>> STAGE);
      dat_next.yt = in_dat.yt + (in_dat.xt >>> STAGE);
      dat_next.zt = in_dat.zt - ANGLE;
    end else begin
      dat_next.xt = in_dat.xt + (in_dat.yt >>> STAGE);
      dat_next.yt = in_dat.yt - (in_dat.xt >>> STAGE);
      dat_next.zt = in_dat.zt + ANGLE;
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dat <= dat_next;
      ctl <= in_ctl;
    end
  end

  assign out_valid = vld;
  assign out_dat   = dat;
  assign out_ctl   = ctl;

endmodule

// ----- design/svg_post.sv -----
// Post-processing pipeline: rounds the CORDIC results, maps quadrants, scales by
// the radius and selects pole and error results. Its last stage is the output register.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_post #(
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      radius,
  input  logic             in_valid,
  output logic             in_ready,
  input  svg_pkg::cordic_t in_dat,
  input  svg_pkg::ctrl_t   in_ctl,
  output logic             out_valid,
  input  logic             out_ready,
  output svg_pkg::vertex_t out_vtx
);

  localparam int UW = UNIT_FRAC_BITS + 2;       // unit value with sign and headroom
  localparam int PW = 2 * UW;                   // product of two unit values
  localparam int YW = 17 + UW;                  // radius times a unit value
  localparam int RW = 17 + PW;                  // radius times a unit product
  localparam int SH = svg_pkg::INT_FRAC - UNIT_FRAC_BITS;

  localparam logic signed [32:0]   HALF_C = 33'sd1 <<< (SH - 1);
  localparam logic signed [32:0]   ONE_C  = 33'sd1 <<< UNIT_FRAC_BITS;
  localparam logic signed [UW-1:0] ONE_U  = UW'(ONE_C);
  localparam logic signed [PW-1:0] HALF_P = PW'(33'sd1 <<< (UNIT_FRAC_BITS - 1));
  localparam logic signed [YW-1:0] HALF_Y = YW'(33'sd1 <<< (UNIT_FRAC_BITS - 1));
  localparam logic signed [RW-1:0] HALF_R = RW'(64'sd1 <<< (2 * UNIT_FRAC_BITS - 1));

  function automatic logic signed [UW-1:0] unit_round(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = (33'(v) + HALF_C) >>> SH;
    if (t > ONE_C) begin
      t = ONE_C;
    end else if (t < -ONE_C) begin
      t = -ONE_C;
    end
    return UW'(t);
  endfunction

  function automatic logic signed [16:0] pos_sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (t > 64'(svg_pkg::POS_LIMIT)) begin
      t = 64'(svg_pkg::POS_LIMIT);
    end else if (t < -64'(svg_pkg::POS_LIMIT)) begin
      t = -64'(svg_pkg::POS_LIMIT);
    end
    return 17'(t);
  endfunction

  function automatic logic signed [UW-1:0] quad_sin(input logic [1:0] q,
                                                   input logic signed [UW-1:0] c,
                                                   input logic signed [UW-1:0] s);
    logic signed [UW-1:0] r;
    case (q)
      2'd0:    r = s;
      2'd1:    r = c;
      2'd2:    r = -s;
      default: r = -c;
    endcase
    return r;
  endfunction

  function automatic logic signed [UW-1:0] quad_cos(input logic [1:0] q,
                                                   input logic signed [UW-1:0] c,
                                                   input logic signed [UW-1:0] s);
    logic signed [UW-1:0] r;
    case (q)
      2'd0:    r = c;
      2'd1:    r = -s;
      2'd2:    r = -c;
      default: r = s;
    endcase
    return r;
  endfunction

  logic signed [16:0] rad_s;
  assign rad_s = signed'({1'b0, radius});

  // Stage 1: rounded, saturated, quadrant-mapped sine and cosine.
  logic                 s1_vld, s1_rdy;
  svg_pkg::ctrl_t       s1_ctl;
  logic signed [UW-1:0] s1_sb, s1_cb, s1_st, s1_ct;
  logic signed [UW-1:0] cb_raw, sb_raw, ct_raw, st_raw;

  // Stage 2: unit products and radius times cosine of the polar angle.
  logic                 s2_vld, s2_rdy;
  svg_pkg::ctrl_t       s2_ctl;
  logic signed [PW-1:0] s2_px, s2_pz;
  logic signed [YW-1:0] s2_rcb;
  logic signed [UW-1:0] s2_cb, s2_st, s2_ct;

  // Stage 3: radius-scaled products and finished unit fields.
  logic                 s3_vld, s3_rdy;
  svg_pkg::ctrl_t       s3_ctl;
  logic signed [RW-1:0] s3_rpx, s3_rpz;
  logic signed [UW-1:0] s3_nx, s3_nz, s3_cb, s3_st, s3_ct;
  logic signed [16:0]   s3_posy;
  logic signed [PW-1:0] nx_round, nz_round;
  logic signed [YW-1:0] posy_round;

  // Stage 4: output register.
  logic                 s4_vld, s4_rdy;
  svg_pkg::vertex_t     s4_vtx, vtx_next;
  logic signed [RW-1:0] posx_round, posz_round;

  assign s4_rdy   = !s4_vld || out_ready;
  assign s3_rdy   = !s3_vld || s4_rdy;
  assign s2_rdy   = !s2_vld || s3_rdy;
  assign s1_rdy   = !s1_vld || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld <= in_valid;
      end
      if (s2_rdy) begin
        s2_vld <= s1_vld;
      end
      if (s3_rdy) begin
        s3_vld <= s2_vld;
      end
      if (s4_rdy) begin
        s4_vld <= s3_vld;
      end
    end
  end

  always_comb begin
    cb_raw = unit_round(in_dat.xb);
    sb_raw = unit_round(in_dat.yb);
    ct_raw = unit_round(in_dat.xt);
    st_raw = unit_round(in_dat.yt);
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_ctl <= in_ctl;
      s1_sb  <= quad_sin(in_ctl.qb, cb_raw, sb_raw);
      s1_cb  <= quad_cos(in_ctl.qb, cb_raw, sb_raw);
      s1_st  <= quad_sin(in_ctl.qt, ct_raw, st_raw);
      s1_ct  <= quad_cos(in_ctl.qt, ct_raw, st_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld) begin
      s2_ctl <= s1_ctl;
      s2_px  <= PW'(s1_sb) * PW'(s1_ct);
      s2_pz  <= PW'(s1_sb) * PW'(s1_st);
      s2_rcb <= YW'(rad_s) * YW'(s1_cb);
      s2_cb  <= s1_cb;
      s2_st  <= s1_st;
      s2_ct  <= s1_ct;
    end
  end

  always_comb begin
    nx_round   = (s2_px + HALF_P) >>> UNIT_FRAC_BITS;
    nz_round   = (s2_pz + HALF_P) >>> UNIT_FRAC_BITS;
    posy_round = (s2_rcb + HALF_Y) >>> UNIT_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld) begin
      s3_ctl  <= s2_ctl;
      s3_rpx  <= RW'(rad_s) * RW'(s2_px);
      s3_rpz  <= RW'(rad_s) * RW'(s2_pz);
      s3_nx   <= UW'(nx_round);
      s3_nz   <= UW'(nz_round);
      s3_posy <= pos_sat(64'(posy_round));
      s3_cb   <= s2_cb;
      s3_st   <= s2_st;
      s3_ct   <= s2_ct;
    end
  end

  always_comb begin
    posx_round = (s3_rpx + HALF_R) >>> (2 * UNIT_FRAC_BITS);
    posz_round = (s3_rpz + HALF_R) >>> (2 * UNIT_FRAC_BITS);
    vtx_next   = '0;
    if (s3_ctl.err) begin
      vtx_next.index_error = 1'b1;
    end else if (s3_ctl.pole) begin
      vtx_next.is_pole  = 1'b1;
      vtx_next.pos_y    = s3_ctl.south ? -rad_s : rad_s;
      vtx_next.normal_y = 16'(s3_ctl.south ? -ONE_U : ONE_U);
    end else begin
      vtx_next.pos_x     = pos_sat(64'(posx_round));
      vtx_next.pos_y     = s3_posy;
      vtx_next.pos_z     = pos_sat(64'(posz_round));
      vtx_next.normal_x  = 16'(s3_nx);
      vtx_next.normal_y  = 16'(s3_cb);
      vtx_next.normal_z  = 16'(s3_nz);
      vtx_next.tangent_x = 16'(-s3_st);
      vtx_next.tangent_z = 16'(s3_ct);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_vld) begin
      s4_vtx <= vtx_next;
    end
  end

  assign out_valid = s4_vld;
  assign out_vtx   = s4_vtx;

endmodule

// ----- design/sphere_vertex_generator_unit.sv -----
// Top level of the UV sphere vertex generator: register file, request decode,
// the chain of CORDIC cells and the post-processing pipeline.
// Depends on svg_pkg, svg_cordic_cell and svg_post.
//
//   Channel   Direction  Handshake                       Contents
//   s_*       in         s_tvalid / s_tready             ring_index, segment_index
//   m_*       out        m_tvalid / m_tready             position, normal, tangent, flags
//   APB       in/out     psel, penable, pwrite, pready   five configuration registers
//
// One vertex enters per clock and one leaves per clock while m_tready stays high. The
// pipeline is a decode stage, one cell per CORDIC micro-rotation, and four
// post-processing stages ending in the output register.
// Every stage holds its own valid bit and loads whenever the stage after it has room,
// so a stall on m_tready fills empty stages first and back-pressures s_tready only
// when the whole pipeline is occupied.
// Reset (synchronous, active high) empties the pipeline and restores register defaults.
`timescale 1ns / 1ps

module sphere_vertex_generator_unit #(
  parameter int MAX_SUBDIV     = 256,
  parameter int CORDIC_STAGES  = 16,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,

  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata fields from bit 0: ring_index[8:0], segment_index[17:9], zero pad[23:18]
  input  logic [23:0]  s_tdata,

  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata fields from bit 0: pos_x[16:0], pos_y[33:17], pos_z[50:34],
  // normal_x[66:51], normal_y[82:67], normal_z[98:83], tangent_x[114:99],
  // tangent_z[130:115], zero pad[135:131]
  output logic [135:0] m_tdata,
  // m_tuser fields from bit 0: is_pole[0], index_error[1]
  output logic [1:0]   m_tuser,

  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; reads are direct.
  // ---------------------------------------------------------------------------
  logic [15:0] radius;
  logic [8:0]  ring_count;
  logic [8:0]  segment_count;
  logic [15:0] ring_step;
  logic [15:0] segment_step;
  logic [2:0]  reg_index;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= svg_pkg::RADIUS_RESET;
      ring_count    <= svg_pkg::RING_COUNT_RESET;
      segment_count <= svg_pkg::SEGMENT_COUNT_RESET;
      ring_step     <= svg_pkg::RING_STEP_RESET;
      segment_step  <= svg_pkg::SEGMENT_STEP_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        svg_pkg::REG_RADIUS:        radius        <= pwdata[15:0];
        svg_pkg::REG_RING_COUNT:    ring_count    <= pwdata[8:0];
        svg_pkg::REG_SEGMENT_COUNT: segment_count <= pwdata[8:0];
        svg_pkg::REG_RING_STEP:     ring_step     <= pwdata[15:0];
        svg_pkg::REG_SEGMENT_STEP:  segment_step  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      svg_pkg::REG_RADIUS:        prdata = {16'd0, radius};
      svg_pkg::REG_RING_COUNT:    prdata = {23'd0, ring_count};
      svg_pkg::REG_SEGMENT_COUNT: prdata = {23'd0, segment_count};
      svg_pkg::REG_RING_STEP:     prdata = {16'd0, ring_step};
      svg_pkg::REG_SEGMENT_STEP:  prdata = {16'd0, segment_step};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Decode stage: range check, pole detection and the two angles. Each angle is
  // folded into an octant-centered residual and a quadrant code so the CORDIC
  // only ever rotates through plus or minus an eighth of a turn.
  // ---------------------------------------------------------------------------
  logic [8:0]  ring_index, segment_index;
  logic [24:0] ang_b_full, ang_t_full;
  logic [15:0] ang_b_ofs, ang_t_ofs;
  logic        req_err, req_pole;

  assign ring_index    = s_tdata[8:0];
  assign segment_index = s_tdata[17:9];
  assign ang_b_full    = 25'(ring_index) * 25'(ring_step);
  assign ang_t_full    = 25'(segment_index) * 25'(segment_step);
  assign ang_b_ofs     = ang_b_full[15:0] + 16'h2000;
  assign ang_t_ofs     = ang_t_full[15:0] + 16'h2000;

  assign req_err  = (ring_index > ring_count) || (segment_index > segment_count) ||
                    (32'(ring_index) > MAX_SUBDIV) || (32'(segment_index) > MAX_SUBDIV);
  // Ring 0 is tested first, so a ring count of zero still yields the north pole.
  assign req_pole = !req_err && ((ring_index == 9'd0) || (ring_index == ring_count));

  logic [CORDIC_STAGES:0] c_vld, c_rdy;
  svg_pkg::cordic_t       c_dat [CORDIC_STAGES+1];
  svg_pkg::ctrl_t         c_ctl [CORDIC_STAGES+1];

  logic             f_vld;
  svg_pkg::cordic_t f_dat;
  svg_pkg::ctrl_t   f_ctl;

  assign s_tready = !f_vld || c_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (s_tready) begin
      f_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      f_dat.xb    <= svg_pkg::CORDIC_GAIN;
      f_dat.yb    <= 32'sd0;
      f_dat.zb    <= signed'({2'b00, ang_b_ofs[13:0], 16'h0000}) - svg_pkg::EIGHTH_TURN;
      f_dat.xt    <= svg_pkg::CORDIC_GAIN;
      f_dat.yt    <= 32'sd0;
      f_dat.zt    <= signed'({2'b00, ang_t_ofs[13:0], 16'h0000}) - svg_pkg::EIGHTH_TURN;
      f_ctl.err   <= req_err;
      f_ctl.pole  <= req_pole;
      f_ctl.south <= (ring_index != 9'd0);
      f_ctl.qb    <= ang_b_ofs[15:14];
      f_ctl.qt    <= ang_t_ofs[15:14];
    end
  end

  assign c_vld[0] = f_vld;
  assign c_dat[0] = f_dat;
  assign c_ctl[0] = f_ctl;

  // ---------------------------------------------------------------------------
  // Chain of CORDIC cells, one micro-rotation per cell, both angles side by side.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    svg_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_vld[k]),
      .in_ready  (c_rdy[k]),
      .in_dat    (c_dat[k]),
      .in_ctl    (c_ctl[k]),
      .out_valid (c_vld[k+1]),
      .out_ready (c_rdy[k+1]),
      .out_dat   (c_dat[k+1]),
      .out_ctl   (c_ctl[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Rounding, radius scaling and result selection; the output register is inside.
  // ---------------------------------------------------------------------------
  svg_pkg::vertex_t vtx;

  svg_post #(
    .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .in_valid  (c_vld[CORDIC_STAGES]),
    .in_ready  (c_rdy[CORDIC_STAGES]),
    .in_dat    (c_dat[CORDIC_STAGES]),
    .in_ctl    (c_ctl[CORDIC_STAGES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_vtx   (vtx)
  );

  assign m_tdata = {5'd0, vtx.tangent_z, vtx.tangent_x, vtx.normal_z, vtx.normal_y,
                    vtx.normal_x, vtx.pos_z, vtx.pos_y, vtx.pos_x};
  assign m_tuser = {vtx.index_error, vtx.is_pole};

endmodule

// ----- design/svg_checker.sv -----
// Port-level checks for the sphere vertex generator, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module svg_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic [1:0]   m_tuser
);

  // A stalled result transfer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // An index error carries nothing but the error flag.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == 136'd0))
    else $error("error result carries data");

  // A pole has no x or z position, no x or z normal and no tangent.
  a_pole_axis: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[16:0] == 17'd0) && (m_tdata[66:34] == 33'd0) &&
                              (m_tdata[135:83] == 53'd0))
    else $error("pole result off the y axis");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sphere_vertex_generator_unit svg_checker u_svg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
